@@ hdl/sckt_pkg.sv @@
// Shared types and constants of the scan-code pressed-key tracker.
package sckt_pkg;

  localparam int unsigned TableDepth = 4;
  localparam int unsigned KeyW = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CountW = $clog2(TableDepth + 1);
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [ByteW-1:0] PrefixByte = 8'hE0;
  localparam logic [ByteW-1:0] ReleaseBit = 8'h80;

  typedef struct packed {
    logic            release_key;
    logic [KeyW-1:0] key;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

@@ hdl/sckt_in_if.sv @@
// Input channel carrying one raw scan-code byte per item.
interface sckt_in_if;
  import sckt_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] code_byte;

  modport source (output valid, output code_byte, input ready);
  modport sink (input valid, input code_byte, output ready);

endinterface

@@ hdl/sckt_out_if.sv @@
// Output channel carrying the held-key table and its count per item.
interface sckt_out_if;
  import sckt_pkg::*;

  logic              valid;
  logic              ready;
  logic [CountW-1:0] key_count;
  logic [KeyW-1:0]   held_key_a;
  logic [KeyW-1:0]   held_key_b;
  logic [KeyW-1:0]   held_key_c;
  logic [KeyW-1:0]   held_key_d;

  modport source (output valid, output key_count, output held_key_a, output held_key_b,
                  output held_key_c, output held_key_d, input ready);
  modport sink (input valid, input key_count, input held_key_a, input held_key_b,
                input held_key_c, input held_key_d, output ready);

endinterface

@@ hdl/sckt_front.sv @@
// Front end: accepts scan-code bytes, merges the prefix and classifies press or release.
module sckt_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  sckt_in_if.sink                in_i,
  input  sckt_pkg::queue_status_t status_i,
  output logic                   push_o,
  output sckt_pkg::cmd_t         push_cmd_o
);
  import sckt_pkg::*;

  logic             prefix_q, prefix_d;
  logic             accept;
  logic             is_prefix;
  logic [ByteW-1:0] high_byte;

  assign in_i.ready = !status_i.full;
  assign accept     = in_i.valid && in_i.ready;
  assign is_prefix  = !prefix_q && (in_i.code_byte == PrefixByte);
  assign high_byte  = prefix_q ? PrefixByte : '0;

  always_comb begin
    push_cmd_o.release_key = in_i.code_byte > ReleaseBit;
    if (push_cmd_o.release_key) begin
      push_cmd_o.key = {high_byte, in_i.code_byte - ReleaseBit};
    end else begin
      push_cmd_o.key = {high_byte, in_i.code_byte};
    end
  end

  assign push_o = accept && !is_prefix;

  always_comb begin
    prefix_d = prefix_q;
    if (accept) begin
      prefix_d = is_prefix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= 1'b0;
    end else begin
      prefix_q <= prefix_d;
    end
  end

endmodule

@@ hdl/sckt_queue.sv @@
// Short command queue between the front end and the table engine.
module sckt_queue #(
  parameter int unsigned QueueDepth = sckt_pkg::QueueDepthDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  sckt_pkg::cmd_t          push_cmd_i,
  input  logic                    pop_i,
  output sckt_pkg::cmd_t          pop_cmd_o,
  output sckt_pkg::queue_status_t status_o
);
  import sckt_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned FillW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [FillW-1:0] FullFill = FillW'(QueueDepth);

  cmd_t             entry_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             do_push, do_pop;

  assign status_o.full  = fill_q == FullFill;
  assign status_o.empty = fill_q == '0;
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign pop_cmd_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ hdl/sckt_back.sv @@
// Table engine: applies press and release commands to the held-key table and reports it.
module sckt_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sckt_pkg::queue_status_t status_i,
  input  sckt_pkg::cmd_t          pop_cmd_i,
  output logic                    pop_o,
  sckt_out_if.source              out_o
);
  import sckt_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StExec = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;
  localparam logic [CountW-1:0] FullCount = CountW'(TableDepth);

  logic [1:0]        state_q, state_d;
  cmd_t              cmd_q;
  logic [KeyW-1:0]   table_q [TableDepth];
  logic [KeyW-1:0]   table_d [TableDepth];
  logic [CountW-1:0] count_q, count_d;
  logic              hit;
  logic [IdxW-1:0]   hit_idx;
  logic              emit;

  assign pop_o = (state_q == StIdle) && !status_i.empty;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int k = TableDepth - 1; k >= 0; k--) begin
      if ((CountW'(k) < count_q) && (table_q[k] == cmd_q.key)) begin
        hit     = 1'b1;
        hit_idx = IdxW'(k);
      end
    end
  end

  always_comb begin
    table_d = table_q;
    count_d = count_q;
    emit    = 1'b0;
    if (state_q == StExec) begin
      if (cmd_q.release_key) begin
        emit = 1'b1;
        if (hit) begin
          for (int k = 0; k < TableDepth - 1; k++) begin
            if (IdxW'(k) >= hit_idx) begin
              table_d[k] = table_q[k+1];
            end
          end
          table_d[TableDepth-1] = '0;
          count_d = count_q - 1'b1;
        end
      end else if (count_q < FullCount) begin
        emit = 1'b1;
        if (!hit) begin
          table_d[count_q[IdxW-1:0]] = cmd_q.key;
          count_d = count_q + 1'b1;
        end
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (pop_o) begin
          state_d = StExec;
        end
      end
      StExec: begin
        state_d = emit ? StOut : StIdle;
      end
      StOut: begin
        if (out_o.ready) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      for (int k = 0; k < TableDepth; k++) begin
        table_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      table_q <= table_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= pop_cmd_i;
    end
  end

  assign out_o.valid      = state_q == StOut;
  assign out_o.key_count  = count_q;
  assign out_o.held_key_a = table_q[0];
  assign out_o.held_key_b = table_q[1];
  assign out_o.held_key_c = table_q[2];
  assign out_o.held_key_d = table_q[3];

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= FullCount)
    else $error("Held-key count exceeds the table depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q < FullCount) |-> (table_q[TableDepth-1] == '0))
    else $error("Unused table slot is not zero.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut && !out_o.ready) |=> ($stable(count_q) && $stable(table_q[0])))
    else $error("Table changed while a result was waiting.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StExec && cmd_q.release_key) |=> (count_q <= $past(count_q)))
    else $error("A release increased the held-key count.");
`endif

endmodule

@@ hdl/scancode_pressed_key_tracker.sv @@
// An accepted non-prefix byte is queued, loaded into the engine, applied to the table and shown.
// The table engine takes a new code only from idle and steps through fetch, update and send.
// A prefix byte only sets the front end flag; a press to a full table is dropped without a result.
// The command queue lets bytes be accepted while a result waits to be taken.
// Reset clears the prefix flag, the queue, the table and the count; no item is shown after it.
module scancode_pressed_key_tracker #(
  parameter int unsigned QueueDepth = sckt_pkg::QueueDepthDefault
) (
  input logic        clk_i,
  input logic        rst_ni,
  sckt_in_if.sink    in_i,
  sckt_out_if.source out_o
);
  import sckt_pkg::*;

  logic          push;
  cmd_t          push_cmd;
  logic          pop;
  cmd_t          pop_cmd;
  queue_status_t status;

  sckt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .status_i   (status),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  sckt_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .status_o   (status)
  );

  sckt_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .status_i  (status),
    .pop_cmd_i (pop_cmd),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule
